@@ rtl/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths, latency helper and case codes for the segment closest-point
// pipeline.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned PROD_W   = 2 * DIFF_W;
  localparam int unsigned DOT_W    = PROD_W + 2;
  localparam int unsigned BIG_W    = 2 * DOT_W + 1;
  localparam int unsigned SQ_W     = 2 * DIFF_W;
  localparam int unsigned PARAM_W  = 17;
  localparam int unsigned GAP_W    = 63;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned CHUNK_W  = 16;

  localparam int unsigned PARAM_FRAC_BITS_DEF = 16;

  typedef enum logic [CODE_W-1:0] {
    CASE_BOTH_DEG   = 3'd0,
    CASE_FIRST_DEG  = 3'd1,
    CASE_SECOND_DEG = 3'd2,
    CASE_GENERAL    = 3'd3,
    CASE_PARALLEL   = 3'd4
  } case_code_e;

  // cycles through ssc_mul for a multiplier operand of wb bits
  function automatic int unsigned mul_lat(input int unsigned wb);
    return (wb + CHUNK_W - 1) / CHUNK_W + 2;
  endfunction

endpackage

@@ rtl/ssc_dly.sv @@
// ----------------------------------------------------------------------------
// ssc_dly
// Stallable delay line that carries side data alongside the pipeline.
// ----------------------------------------------------------------------------
module ssc_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

@@ rtl/ssc_mul.sv @@
// ----------------------------------------------------------------------------
// ssc_mul
// Pipelined signed multiplier: sign-magnitude split, then one chunk of the
// second operand per stage, then the sign is put back.
// ----------------------------------------------------------------------------
module ssc_mul import ssc_pkg::*; #(
  parameter int unsigned WA = 33,
  parameter int unsigned WB = 33
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int unsigned NCH = (WB + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned BPW = NCH * CHUNK_W;
  localparam int unsigned PW  = WA + WB;
  localparam int unsigned XW  = WA + CHUNK_W + BPW;

  logic [WA-1:0]  am_q  [NCH];
  logic [BPW-1:0] bm_q  [NCH];
  logic           neg_q [NCH+1];
  logic [PW-1:0]  acc_q [NCH];
  logic [PW-1:0]  p_q;
  logic [WA-1:0]  am_d;
  logic [WB-1:0]  bm_d;

  assign am_d = a_i[WA-1] ? WA'(~a_i + 1'b1) : WA'(a_i);
  assign bm_d = b_i[WB-1] ? WB'(~b_i + 1'b1) : WB'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am_q[0]  <= am_d;
      bm_q[0]  <= BPW'(bm_d);
      neg_q[0] <= a_i[WA-1] ^ b_i[WB-1];
    end
  end

  for (genvar k = 0; k < NCH; k++) begin : g_chunk
    logic [WA+CHUNK_W-1:0] pp_w;
    logic [XW-1:0]         sh_w;
    logic [PW-1:0]         prev_w;

    assign pp_w = am_q[k] * bm_q[k][k*CHUNK_W +: CHUNK_W];
    assign sh_w = XW'(pp_w) << (k * CHUNK_W);

    if (k == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_next
      assign prev_w = acc_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k]   <= prev_w + sh_w[PW-1:0];
        neg_q[k+1] <= neg_q[k];
      end
    end

    if (k + 1 < NCH) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          am_q[k+1] <= am_q[k];
          bm_q[k+1] <= bm_q[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg_q[NCH] ? PW'(~acc_q[NCH-1] + 1'b1) : acc_q[NCH-1];
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/ssc_div.sv @@
// ----------------------------------------------------------------------------
// ssc_div
// Pipelined clamped quotient n/m in Q1.QB, one restoring step per stage.
// m must be positive; n <= 0 gives 0 and n >= m gives 1.0.
// ----------------------------------------------------------------------------
module ssc_div #(
  parameter int unsigned W  = 64,
  parameter int unsigned QB = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] n_i,
  input  logic signed [W-1:0] m_i,
  output logic [QB:0]         q_o
);

  logic          zero_q [QB+1];
  logic          one_q  [QB+1];
  logic [W-2:0]  rem_q  [QB+1];
  logic [W-2:0]  m_q    [QB];
  logic [QB-1:0] qa_q   [QB];
  logic [QB:0]   q_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= n_i[W-1] || (n_i == '0);
      one_q[0]  <= (n_i >= m_i);
      rem_q[0]  <= n_i[W-2:0];
      m_q[0]    <= m_i[W-2:0];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_bit
    logic [W-1:0]  sh_w;
    logic [W-1:0]  sub_w;
    logic          ge_w;
    logic [QB-1:0] prev_w;

    assign sh_w  = {rem_q[j], 1'b0};
    assign ge_w  = (sh_w >= {1'b0, m_q[j]});
    assign sub_w = sh_w - {1'b0, m_q[j]};

    if (j == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_next
      assign prev_w = qa_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= ge_w ? sub_w[W-2:0] : sh_w[W-2:0];
        qa_q[j]     <= {prev_w[QB-2:0], ge_w};
        zero_q[j+1] <= zero_q[j];
        one_q[j+1]  <= one_q[j];
      end
    end

    if (j + 1 < QB) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          m_q[j+1] <= m_q[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[QB]) begin
        q_q <= '0;
      end else if (one_q[QB]) begin
        q_q <= {1'b1, {QB{1'b0}}};
      end else begin
        q_q <= {1'b0, qa_q[QB-1]};
      end
    end
  end

  assign q_o = q_q;

endmodule

@@ rtl/segment_segment_closest_points_top.sv @@
// ----------------------------------------------------------------------------
// segment_segment_closest_points_top
// Closest points, clamped parameters and squared distance between two 3D
// segments, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o  | first/second start/end x,y,z
//  out     | out_valid_o / out_ready_i| near points, params, gap, case code
//
//  the pipeline depth comes mostly from the two one-bit-per-stage quotient
//  pipelines and the chunked wide multipliers
//  one item enters per clock; the whole pipeline freezes while the output
//  holds an item that is not taken
//  reset clears only the valid bits
// ----------------------------------------------------------------------------
module segment_segment_closest_points_top import ssc_pkg::*; #(
  parameter int unsigned PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] first_start_x_i,
  input  logic signed [COORD_W-1:0] first_start_y_i,
  input  logic signed [COORD_W-1:0] first_start_z_i,
  input  logic signed [COORD_W-1:0] first_end_x_i,
  input  logic signed [COORD_W-1:0] first_end_y_i,
  input  logic signed [COORD_W-1:0] first_end_z_i,
  input  logic signed [COORD_W-1:0] second_start_x_i,
  input  logic signed [COORD_W-1:0] second_start_y_i,
  input  logic signed [COORD_W-1:0] second_start_z_i,
  input  logic signed [COORD_W-1:0] second_end_x_i,
  input  logic signed [COORD_W-1:0] second_end_y_i,
  input  logic signed [COORD_W-1:0] second_end_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [COORD_W-1:0] near_first_x_o,
  output logic signed [COORD_W-1:0] near_first_y_o,
  output logic signed [COORD_W-1:0] near_first_z_o,
  output logic signed [COORD_W-1:0] near_second_x_o,
  output logic signed [COORD_W-1:0] near_second_y_o,
  output logic signed [COORD_W-1:0] near_second_z_o,
  output logic [PARAM_W-1:0]        param_first_o,
  output logic [PARAM_W-1:0]        param_second_o,
  output logic [GAP_W-1:0]          squared_gap_o,
  output logic [CODE_W-1:0]         case_code_o
);

  localparam int unsigned P     = PARAM_FRAC_BITS;
  localparam int unsigned TW    = P + 1;
  localparam int unsigned NW    = DOT_W + P + 3;
  localparam int unsigned PMW   = DIFF_W + TW + 1;
  localparam int unsigned SUM_W = SQ_W + 2;
  localparam int unsigned BTW   = DOT_W + P + 2;
  localparam int unsigned SIDEW = 2 + 2 * TW;

  localparam int unsigned LM1 = mul_lat(DIFF_W);
  localparam int unsigned LM2 = mul_lat(DOT_W);
  localparam int unsigned LM3 = mul_lat(P + 2);
  localparam int unsigned LD  = P + 2;

  localparam int unsigned T_DOT  = 1 + LM1;
  localparam int unsigned T_SUM  = T_DOT + 1;
  localparam int unsigned T_BIG  = T_SUM + LM2;
  localparam int unsigned T_DEN  = T_BIG + 1;
  localparam int unsigned T_DIV1 = T_DEN + LD;
  localparam int unsigned T_BT   = T_DIV1 + LM3;
  localparam int unsigned T_N    = T_BT + 1;
  localparam int unsigned T_SEL  = T_N + 1;
  localparam int unsigned T_DIV2 = T_SEL + LD;
  localparam int unsigned T_T    = T_DIV2 + 1;
  localparam int unsigned T_PM   = T_T + 1;
  localparam int unsigned T_PT   = T_PM + 1;
  localparam int unsigned T_MAG  = T_PT + 1;
  localparam int unsigned T_SQ   = T_MAG + 1;
  localparam int unsigned LAT    = T_SQ + 1;

  localparam logic [TW-1:0]          T_ONE   = {1'b1, {P{1'b0}}};
  localparam logic signed [PMW-1:0]  HALF    = PMW'(1) << (P - 1);
  localparam logic [SUM_W-1:0]       GAP_MAX = SUM_W'({GAP_W{1'b1}});

  logic en;
  logic [LAT:1] vld_q;

  assign en          = !vld_q[LAT] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-1:1], in_valid_i};
    end
  end

  // ---- input stage: differences
  logic signed [COORD_W-1:0] fs [3];
  logic signed [COORD_W-1:0] fe [3];
  logic signed [COORD_W-1:0] ss [3];
  logic signed [COORD_W-1:0] se [3];

  assign fs[0] = first_start_x_i;
  assign fs[1] = first_start_y_i;
  assign fs[2] = first_start_z_i;
  assign fe[0] = first_end_x_i;
  assign fe[1] = first_end_y_i;
  assign fe[2] = first_end_z_i;
  assign ss[0] = second_start_x_i;
  assign ss[1] = second_start_y_i;
  assign ss[2] = second_start_z_i;
  assign se[0] = second_end_x_i;
  assign se[1] = second_end_y_i;
  assign se[2] = second_end_z_i;

  logic signed [COORD_W-1:0] s1_q [3];
  logic signed [COORD_W-1:0] s2_q [3];
  logic signed [DIFF_W-1:0]  d1_q [3];
  logic signed [DIFF_W-1:0]  d2_q [3];
  logic signed [DIFF_W-1:0]  r_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_q[k] <= fs[k];
        s2_q[k] <= ss[k];
        d1_q[k] <= DIFF_W'(fe[k]) - DIFF_W'(fs[k]);
        d2_q[k] <= DIFF_W'(se[k]) - DIFF_W'(ss[k]);
        r_q[k]  <= DIFF_W'(fs[k]) - DIFF_W'(ss[k]);
      end
    end
  end

  logic deg1, deg2;
  assign deg1 = (d1_q[0] == '0) && (d1_q[1] == '0) && (d1_q[2] == '0);
  assign deg2 = (d2_q[0] == '0) && (d2_q[1] == '0) && (d2_q[2] == '0);

  // ---- dot products
  logic signed [PROD_W-1:0] pa [3];
  logic signed [PROD_W-1:0] pb [3];
  logic signed [PROD_W-1:0] pc [3];
  logic signed [PROD_W-1:0] pe [3];
  logic signed [PROD_W-1:0] pf [3];

  for (genvar k = 0; k < 3; k++) begin : g_dot
    ssc_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_pa (
      .clk_i, .en_i(en), .a_i(d1_q[k]), .b_i(d1_q[k]), .p_o(pa[k])
    );
    ssc_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_pb (
      .clk_i, .en_i(en), .a_i(d1_q[k]), .b_i(d2_q[k]), .p_o(pb[k])
    );
    ssc_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_pc (
      .clk_i, .en_i(en), .a_i(d1_q[k]), .b_i(r_q[k]), .p_o(pc[k])
    );
    ssc_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_pe (
      .clk_i, .en_i(en), .a_i(d2_q[k]), .b_i(d2_q[k]), .p_o(pe[k])
    );
    ssc_mul #(.WA(DIFF_W), .WB(DIFF_W)) u_pf (
      .clk_i, .en_i(en), .a_i(d2_q[k]), .b_i(r_q[k]), .p_o(pf[k])
    );
  end

  logic signed [DOT_W-1:0] a_q, b_q, c_q, e_q, f_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= DOT_W'(pa[0]) + DOT_W'(pa[1]) + DOT_W'(pa[2]);
      b_q <= DOT_W'(pb[0]) + DOT_W'(pb[1]) + DOT_W'(pb[2]);
      c_q <= DOT_W'(pc[0]) + DOT_W'(pc[1]) + DOT_W'(pc[2]);
      e_q <= DOT_W'(pe[0]) + DOT_W'(pe[1]) + DOT_W'(pe[2]);
      f_q <= DOT_W'(pf[0]) + DOT_W'(pf[1]) + DOT_W'(pf[2]);
    end
  end

  // ---- denominator and numerator of t1
  logic signed [2*DOT_W-1:0] p_ae, p_bb, p_bf, p_ce;

  ssc_mul #(.WA(DOT_W), .WB(DOT_W)) u_ae (
    .clk_i, .en_i(en), .a_i(a_q), .b_i(e_q), .p_o(p_ae)
  );
  ssc_mul #(.WA(DOT_W), .WB(DOT_W)) u_bb (
    .clk_i, .en_i(en), .a_i(b_q), .b_i(b_q), .p_o(p_bb)
  );
  ssc_mul #(.WA(DOT_W), .WB(DOT_W)) u_bf (
    .clk_i, .en_i(en), .a_i(b_q), .b_i(f_q), .p_o(p_bf)
  );
  ssc_mul #(.WA(DOT_W), .WB(DOT_W)) u_ce (
    .clk_i, .en_i(en), .a_i(c_q), .b_i(e_q), .p_o(p_ce)
  );

  logic signed [BIG_W-1:0] den_q, num_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q <= BIG_W'(p_ae) - BIG_W'(p_bb);
      num_q <= BIG_W'(p_bf) - BIG_W'(p_ce);
    end
  end

  logic          den_nz;
  logic [TW-1:0] t1g;
  logic          nz_div;
  logic [TW-1:0] t1e;

  assign den_nz = (den_q != '0);

  ssc_div #(.W(BIG_W), .QB(P)) u_div_t1 (
    .clk_i, .en_i(en), .n_i(num_q), .m_i(den_q), .q_o(t1g)
  );

  ssc_dly #(.W(1), .N(LD)) u_dly_nz (
    .clk_i, .en_i(en), .d_i(den_nz), .q_o(nz_div)
  );

  // parallel segments start from t1 = 0
  assign t1e = nz_div ? t1g : '0;

  // ---- N = b*t1 + f scaled
  logic signed [DOT_W-1:0] b_div;
  logic signed [BTW-1:0]   bt_p;

  ssc_dly #(.W(DOT_W), .N(T_DIV1 - T_SUM)) u_dly_bdiv (
    .clk_i, .en_i(en), .d_i(b_q), .q_o(b_div)
  );

  ssc_mul #(.WA(DOT_W), .WB(P + 2)) u_bt (
    .clk_i, .en_i(en), .a_i(b_div), .b_i($signed({1'b0, t1e})), .p_o(bt_p)
  );

  logic signed [DOT_W-1:0] a_b, b_b, c_b, e_b, f_b;
  logic                    deg1_b, deg2_b, nz_b;
  logic [TW-1:0]           t1e_b;

  ssc_dly #(.W(5 * DOT_W), .N(T_BT - T_SUM)) u_dly_dots (
    .clk_i, .en_i(en),
    .d_i({a_q, b_q, c_q, e_q, f_q}),
    .q_o({a_b, b_b, c_b, e_b, f_b})
  );
  ssc_dly #(.W(2), .N(T_BT - 1)) u_dly_deg (
    .clk_i, .en_i(en), .d_i({deg1, deg2}), .q_o({deg1_b, deg2_b})
  );
  ssc_dly #(.W(1 + TW), .N(LM3)) u_dly_t1e (
    .clk_i, .en_i(en), .d_i({nz_div, t1e}), .q_o({nz_b, t1e_b})
  );

  logic signed [NW-1:0]    n_q;
  logic signed [DOT_W-1:0] a_n, b_n, c_n, e_n, f_n;
  logic                    deg1_n, deg2_n, nz_n;
  logic [TW-1:0]           t1e_n;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q    <= NW'(bt_p) + (NW'(f_b) <<< P);
      a_n    <= a_b;
      b_n    <= b_b;
      c_n    <= c_b;
      e_n    <= e_b;
      f_n    <= f_b;
      deg1_n <= deg1_b;
      deg2_n <= deg2_b;
      nz_n   <= nz_b;
      t1e_n  <= t1e_b;
    end
  end

  // ---- choose the final quotient and where it goes
  logic signed [NW-1:0] e1_w, fl_w, negc_w, bmc_w, a_w;
  logic signed [NW-1:0] dn_d, dm_d;
  logic                 q_t1_d, q_t2_d;
  logic [TW-1:0]        fix_t1_d, fix_t2_d;
  case_code_e           code_d;

  assign e1_w   = NW'(e_n) <<< P;
  assign fl_w   = NW'(f_n) <<< P;
  assign a_w    = NW'(a_n);
  assign negc_w = -NW'(c_n);
  assign bmc_w  = NW'(b_n) - NW'(c_n);

  always_comb begin
    dn_d     = '0;
    dm_d     = NW'(1);
    q_t1_d   = 1'b0;
    q_t2_d   = 1'b0;
    fix_t1_d = '0;
    fix_t2_d = '0;
    code_d   = CASE_BOTH_DEG;
    if (deg1_n && deg2_n) begin
      code_d = CASE_BOTH_DEG;
    end else if (deg1_n) begin
      code_d = CASE_FIRST_DEG;
      dn_d   = fl_w;
      dm_d   = e1_w;
      q_t2_d = 1'b1;
    end else if (deg2_n) begin
      code_d = CASE_SECOND_DEG;
      dn_d   = negc_w;
      dm_d   = a_w;
      q_t1_d = 1'b1;
    end else begin
      code_d = nz_n ? CASE_GENERAL : CASE_PARALLEL;
      if (n_q < 0) begin
        dn_d   = negc_w;
        dm_d   = a_w;
        q_t1_d = 1'b1;
      end else if (n_q > e1_w) begin
        dn_d     = bmc_w;
        dm_d     = a_w;
        q_t1_d   = 1'b1;
        fix_t2_d = T_ONE;
      end else begin
        dn_d     = n_q;
        dm_d     = e1_w;
        q_t2_d   = 1'b1;
        fix_t1_d = t1e_n;
      end
    end
  end

  logic signed [NW-1:0] dn_q, dm_q;
  logic [SIDEW-1:0]     side_q;
  case_code_e           code_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dn_q   <= dn_d;
      dm_q   <= dm_d;
      side_q <= {q_t1_d, q_t2_d, fix_t1_d, fix_t2_d};
      code_q <= code_d;
    end
  end

  logic [TW-1:0]    q2;
  logic [SIDEW-1:0] side_v;
  logic             q_t1_v, q_t2_v;
  logic [TW-1:0]    fix_t1_v, fix_t2_v;

  ssc_div #(.W(NW), .QB(P)) u_div_fin (
    .clk_i, .en_i(en), .n_i(dn_q), .m_i(dm_q), .q_o(q2)
  );

  ssc_dly #(.W(SIDEW), .N(LD)) u_dly_side (
    .clk_i, .en_i(en), .d_i(side_q), .q_o(side_v)
  );

  assign {q_t1_v, q_t2_v, fix_t1_v, fix_t2_v} = side_v;

  logic [TW-1:0] t1_q, t2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q <= q_t1_v ? q2 : fix_t1_v;
      t2_q <= q_t2_v ? q2 : fix_t2_v;
    end
  end

  // ---- points, rounded half up
  logic signed [DIFF_W-1:0]  d1_t [3];
  logic signed [DIFF_W-1:0]  d2_t [3];
  logic signed [COORD_W-1:0] s1_p [3];
  logic signed [COORD_W-1:0] s2_p [3];
  logic signed [PMW-1:0]     pm1_q [3];
  logic signed [PMW-1:0]     pm2_q [3];
  logic signed [COORD_W-1:0] c1_q [3];
  logic signed [COORD_W-1:0] c2_q [3];
  logic signed [COORD_W-1:0] c1_o [3];
  logic signed [COORD_W-1:0] c2_o [3];

  for (genvar k = 0; k < 3; k++) begin : g_pt
    ssc_dly #(.W(2 * DIFF_W), .N(T_T - 1)) u_dly_d (
      .clk_i, .en_i(en), .d_i({d1_q[k], d2_q[k]}), .q_o({d1_t[k], d2_t[k]})
    );
    ssc_dly #(.W(2 * COORD_W), .N(T_PM - 1)) u_dly_s (
      .clk_i, .en_i(en), .d_i({s1_q[k], s2_q[k]}), .q_o({s1_p[k], s2_p[k]})
    );
    ssc_dly #(.W(2 * COORD_W), .N(LAT - T_PT)) u_dly_c (
      .clk_i, .en_i(en), .d_i({c1_q[k], c2_q[k]}), .q_o({c1_o[k], c2_o[k]})
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pm1_q[k] <= d1_t[k] * $signed({1'b0, t1_q});
        pm2_q[k] <= d2_t[k] * $signed({1'b0, t2_q});
        c1_q[k]  <= COORD_W'(PMW'(s1_p[k]) + ((pm1_q[k] + HALF) >>> P));
        c2_q[k]  <= COORD_W'(PMW'(s2_p[k]) + ((pm2_q[k] + HALF) >>> P));
      end
    end
  end

  // ---- squared gap, saturating
  logic signed [DIFF_W-1:0] diff_w [3];
  logic [DIFF_W-1:0]        mag_d  [3];
  logic [DIFF_W-1:0]        mag_q  [3];
  logic [SQ_W-1:0]          sq_q   [3];
  logic [SUM_W-1:0]         sum_w;
  logic [GAP_W-1:0]         gap_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_w[k] = DIFF_W'(c2_q[k]) - DIFF_W'(c1_q[k]);
      mag_d[k]  = diff_w[k][DIFF_W-1] ? DIFF_W'(-diff_w[k]) : DIFF_W'(diff_w[k]);
    end
  end

  assign sum_w = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag_q[k] <= mag_d[k];
        sq_q[k]  <= mag_q[k] * mag_q[k];
      end
      gap_q <= (sum_w > GAP_MAX) ? GAP_MAX[GAP_W-1:0] : sum_w[GAP_W-1:0];
    end
  end

  // ---- side data to the output register
  logic [TW-1:0]     t1_o, t2_o;
  logic [CODE_W-1:0] code_o;

  ssc_dly #(.W(2 * TW), .N(LAT - T_T)) u_dly_t (
    .clk_i, .en_i(en), .d_i({t1_q, t2_q}), .q_o({t1_o, t2_o})
  );
  ssc_dly #(.W(CODE_W), .N(LAT - T_SEL)) u_dly_code (
    .clk_i, .en_i(en), .d_i(code_q), .q_o(code_o)
  );

  assign near_first_x_o  = c1_o[0];
  assign near_first_y_o  = c1_o[1];
  assign near_first_z_o  = c1_o[2];
  assign near_second_x_o = c2_o[0];
  assign near_second_y_o = c2_o[1];
  assign near_second_z_o = c2_o[2];
  assign param_first_o   = PARAM_W'(t1_o);
  assign param_second_o  = PARAM_W'(t2_o);
  assign squared_gap_o   = gap_q;
  assign case_code_o     = code_o;

endmodule

@@ rtl/ssc_checker.sv @@
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks of the closest-point pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module ssc_checker import ssc_pkg::*; #(
  parameter int unsigned PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [PARAM_W-1:0]  param_first_o,
  input logic [PARAM_W-1:0]  param_second_o,
  input logic [GAP_W-1:0]    squared_gap_o,
  input logic [CODE_W-1:0]   case_code_o
);

  localparam int unsigned T_ONE = 1 << PARAM_FRAC_BITS;

  // a result that is held back stays valid and keeps its gap, case code and first parameter
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(squared_gap_o)
      && $stable(case_code_o) && $stable(param_first_o))
    else $error("held result changed");

  // an empty output stage never blocks the input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && case_code_o == CASE_BOTH_DEG |->
      param_first_o == '0 && param_second_o == '0)
    else $error("degenerate pair with nonzero parameter");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && case_code_o == CASE_FIRST_DEG |-> param_first_o == '0)
    else $error("degenerate first segment with nonzero t1");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> param_first_o <= T_ONE && param_second_o <= T_ONE)
    else $error("parameter above one");

endmodule

bind segment_segment_closest_points_top ssc_checker #(
  .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
) u_ssc_checker (.*);
